// ----- rtl/qtg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtg_pkg
// Shared types and constants of the quintic trajectory generator.
// ----------------------------------------------------------------------------
package qtg_pkg;

  // Width of the shared serial arithmetic units.
  localparam int unsigned ARITH_W = 64;
  localparam int unsigned CNT_W   = $clog2(ARITH_W);

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  typedef enum logic [2:0] {
    REG_START_ANGLE    = 3'd0,
    REG_END_ANGLE      = 3'd1,
    REG_MOVE_SPEED     = 3'd2,
    REG_STIFFNESS_GAIN = 3'd3,
    REG_DAMPING_GAIN   = 3'd4,
    REG_MOTOR_NUMBER   = 3'd5,
    REG_BUS_NUMBER     = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic        command;
    logic [19:0] tick_us;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] position_cmd;
    logic signed [31:0] velocity_cmd;
    logic               torque_cmd;
    logic [31:0]        stiffness_out;
    logic [31:0]        damping_out;
    logic [3:0]         motor_out;
    logic [1:0]         bus_out;
    logic               moving_flag;
  } out_word_t;

endpackage

// ----- rtl/qtg_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtg_mul
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module qtg_mul (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         go,
  input  logic [qtg_pkg::ARITH_W-1:0]  a,
  input  logic [qtg_pkg::ARITH_W-1:0]  b,
  output logic                         done,
  output logic [qtg_pkg::ARITH_W-1:0]  p
);

  logic                        busy_r;
  logic                        done_r;
  logic [qtg_pkg::ARITH_W-1:0] a_r;
  logic [qtg_pkg::ARITH_W-1:0] b_r;
  logic [qtg_pkg::ARITH_W-1:0] acc_r;

  // The multiplier is consumed from its low end; the run ends as soon as
  // no set bits remain, so short multipliers finish early.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        a_r    <= a;
        b_r    <= b;
        acc_r  <= '0;
      end else if (busy_r) begin
        if (b_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          if (b_r[0]) begin
            acc_r <= acc_r + a_r;
          end
          a_r <= a_r << 1;
          b_r <= b_r >> 1;
        end
      end
    end
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule

// ----- rtl/qtg_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtg_div
// Restoring divider that resolves one quotient bit per cycle.
// ----------------------------------------------------------------------------
module qtg_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         go,
  input  logic [qtg_pkg::ARITH_W-1:0]  n,
  input  logic [qtg_pkg::ARITH_W-1:0]  d,
  output logic                         done,
  output logic [qtg_pkg::ARITH_W-1:0]  q
);

  logic                        busy_r;
  logic                        done_r;
  logic [qtg_pkg::CNT_W-1:0]   cnt_r;
  logic [qtg_pkg::ARITH_W-1:0] n_r;
  logic [qtg_pkg::ARITH_W-1:0] d_r;
  logic [qtg_pkg::ARITH_W:0]   rem_r;
  logic [qtg_pkg::ARITH_W:0]   rem_sh;
  logic                        fits;

  assign rem_sh = {rem_r[qtg_pkg::ARITH_W-1:0], n_r[qtg_pkg::ARITH_W-1]};
  assign fits   = (rem_sh >= {1'b0, d_r});

  // The dividend shifts out of n_r at the top while quotient bits shift in
  // at the bottom, so n_r holds the quotient when the count runs out.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        n_r    <= n;
        d_r    <= d;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= fits ? (rem_sh - {1'b0, d_r}) : rem_sh;
        n_r   <= {n_r[qtg_pkg::ARITH_W-2:0], fits};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == qtg_pkg::CNT_W'(qtg_pkg::ARITH_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign q    = n_r;

endmodule

// ----- rtl/quintic_trajectory_generator_core.sv -----
// ----------------------------------------------------------------------------
// quintic_trajectory_generator_core: minimum-jerk move generator, one word in flight.
// A start runs the setup steps and emits nothing; each tick emits one result word,
// and a stalled result holds the emit step. Synchronous active-low reset
// clears control, configuration and move state; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quintic_trajectory_generator_core #(
  parameter int unsigned GEAR_RATIO_Q8 = 1620
) (
  input  logic                clk,
  input  logic                rst_n,
  // Input channel: tick and start words.
  input  logic                in_valid,
  output logic                in_stall,
  input  qtg_pkg::in_word_t   in_word,
  // Result channel: one command word per tick.
  output logic                out_valid,
  input  logic                out_stall,
  output qtg_pkg::out_word_t  out_word,
  // Configuration write channel.
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  // Degrees to rotor radians in Q24: gear ratio (Q8) times pi/180 (Q32).
  localparam logic [63:0] DEG2RAD_Q32 = 64'd74961321;
  localparam logic [63:0] ROTOR_F     = (64'(GEAR_RATIO_Q8) * DEG2RAD_Q32) >> 16;
  localparam logic [63:0] DEN_RAW     = 64'(GEAR_RATIO_Q8) * 64'(GEAR_RATIO_Q8);
  localparam logic [63:0] GAIN_DEN    = (DEN_RAW == 64'd0) ? 64'd1 : DEN_RAW;
  localparam logic [63:0] US_PER_S    = 64'd1000000;
  localparam logic [63:0] VEL_FF_NUM  = 64'd800000;
  localparam logic signed [35:0] ONE_Q30   = 36'sd1073741824;
  localparam logic signed [35:0] VMAX_Q30  = 36'sd2013265920;

  typedef enum logic [4:0] {
    ST_IDLE, ST_KP, ST_KD, ST_SR, ST_ER, ST_DM, ST_DD,
    ST_CHK, ST_T, ST_P2, ST_P3, ST_P4, ST_P5, ST_POLY,
    ST_DP, ST_DV1, ST_DV2, ST_DV3, ST_EMIT
  } state_t;

  state_t state_r;
  logic   pend_r;

  // Configuration registers.
  logic signed [31:0] start_angle_r;
  logic signed [31:0] end_angle_r;
  logic [31:0]        move_speed_r;
  logic [31:0]        stiffness_gain_r;
  logic [31:0]        damping_gain_r;
  logic [3:0]         motor_number_r;
  logic [1:0]         bus_number_r;

  // Move state.
  logic               in_motion_r;
  logic [31:0]        elapsed_r;
  logic [31:0]        duration_r;
  logic signed [31:0] start_rotor_r;
  logic signed [31:0] end_rotor_r;
  logic signed [32:0] dist_r;
  logic signed [31:0] hold_r;
  logic [31:0]        kp_r;
  logic [31:0]        kd_r;

  // Working registers of one tick.
  logic [29:0]        t_r;
  logic [29:0]        t2_r;
  logic [29:0]        t3_r;
  logic [29:0]        t4_r;
  logic [29:0]        t5_r;
  logic [30:0]        ps_r;
  logic [30:0]        vs_r;
  logic [63:0]        tmp_r;
  logic signed [31:0] pos_r;
  logic signed [31:0] vel_r;

  logic               out_valid_r;
  qtg_pkg::out_word_t out_word_r;

  // Shared serial units.
  logic        mul_go;
  logic        mul_done;
  logic [63:0] mul_a;
  logic [63:0] mul_b;
  logic [63:0] mul_p;
  logic        div_go;
  logic        div_done;
  logic [63:0] div_n;
  logic [63:0] div_d;
  logic [63:0] div_q;
  logic        is_mul;
  logic        is_div;

  logic [31:0]        start_mag;
  logic [31:0]        end_mag;
  logic signed [32:0] angle_diff;
  logic [32:0]        angle_mag;
  logic [32:0]        dist_mag;
  logic [32:0]        elapsed_sum;
  logic signed [35:0] ps_raw;
  logic signed [35:0] vs_raw;
  logic signed [35:0] dp_signed;
  logic signed [35:0] pos_sum;

  // Saturate a magnitude with a sign to a signed 32-bit value.
  function automatic logic [31:0] sat_mag(input logic neg, input logic [63:0] m);
    logic [31:0] res;
    if (!neg) begin
      res = (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
    end else begin
      res = (m > 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - m[31:0]);
    end
    return res;
  endfunction

  assign start_mag   = start_angle_r[31] ? (32'd0 - start_angle_r) : start_angle_r;
  assign end_mag     = end_angle_r[31] ? (32'd0 - end_angle_r) : end_angle_r;
  assign angle_diff  = {end_angle_r[31], end_angle_r} - {start_angle_r[31], start_angle_r};
  assign angle_mag   = angle_diff[32] ? (33'd0 - angle_diff) : angle_diff;
  assign dist_mag    = dist_r[32] ? (33'd0 - dist_r) : dist_r;
  assign elapsed_sum = {1'b0, elapsed_r} + 33'(in_word.tick_us);

  // Quintic and its derivative, built from shifts of the stored powers.
  assign ps_raw = ((36'(t3_r) << 3) + (36'(t3_r) << 1))
                - ((36'(t4_r) << 4) - 36'(t4_r))
                + ((36'(t5_r) << 2) + (36'(t5_r) << 1));
  assign vs_raw = ((36'(t2_r) << 5) - (36'(t2_r) << 1))
                - ((36'(t3_r) << 6) - (36'(t3_r) << 2))
                + ((36'(t4_r) << 5) - (36'(t4_r) << 1));

  // Offset along the move in ST_DP, with the direction of travel applied.
  assign dp_signed = dist_r[32] ? (36'sd0 - $signed({2'b00, mul_p[63:30]}))
                                : $signed({2'b00, mul_p[63:30]});
  assign pos_sum   = 36'(start_rotor_r) + dp_signed;

  // Operand selection for the unit that the current step uses.
  always_comb begin
    is_mul = 1'b0;
    is_div = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    div_n  = '0;
    div_d  = '0;
    unique case (state_r)
      ST_KP: begin
        is_div = 1'b1;
        div_n  = {16'd0, stiffness_gain_r, 16'd0};
        div_d  = GAIN_DEN;
      end
      ST_KD: begin
        is_div = 1'b1;
        div_n  = {16'd0, damping_gain_r, 16'd0};
        div_d  = GAIN_DEN;
      end
      ST_SR: begin
        is_mul = 1'b1;
        mul_a  = {32'd0, start_mag};
        mul_b  = ROTOR_F;
      end
      ST_ER: begin
        is_mul = 1'b1;
        mul_a  = {32'd0, end_mag};
        mul_b  = ROTOR_F;
      end
      ST_DM: begin
        is_mul = 1'b1;
        mul_a  = {31'd0, angle_mag};
        mul_b  = US_PER_S;
      end
      ST_DD: begin
        is_div = 1'b1;
        div_n  = tmp_r;
        div_d  = {32'd0, move_speed_r};
      end
      ST_T: begin
        is_div = 1'b1;
        div_n  = {2'b00, elapsed_r, 30'd0};
        div_d  = {32'd0, duration_r};
      end
      ST_P2: begin
        is_mul = 1'b1;
        mul_a  = {34'd0, t_r};
        mul_b  = {34'd0, t_r};
      end
      ST_P3: begin
        is_mul = 1'b1;
        mul_a  = {34'd0, t2_r};
        mul_b  = {34'd0, t_r};
      end
      ST_P4: begin
        is_mul = 1'b1;
        mul_a  = {34'd0, t3_r};
        mul_b  = {34'd0, t_r};
      end
      ST_P5: begin
        is_mul = 1'b1;
        mul_a  = {34'd0, t4_r};
        mul_b  = {34'd0, t_r};
      end
      ST_DP: begin
        is_mul = 1'b1;
        mul_a  = {31'd0, dist_mag};
        mul_b  = {33'd0, ps_r};
      end
      ST_DV1: begin
        is_mul = 1'b1;
        mul_a  = {31'd0, dist_mag};
        mul_b  = {33'd0, vs_r};
      end
      ST_DV2: begin
        is_mul = 1'b1;
        mul_a  = tmp_r;
        mul_b  = VEL_FF_NUM;
      end
      ST_DV3: begin
        is_div = 1'b1;
        div_n  = tmp_r;
        div_d  = {32'd0, duration_r};
      end
      default: begin
        is_mul = 1'b0;
      end
    endcase
  end

  assign mul_go = is_mul && !pend_r;
  assign div_go = is_div && !pend_r;

  qtg_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (mul_go),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .p    (mul_p)
  );

  qtg_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (div_go),
    .n    (div_n),
    .d    (div_d),
    .done (div_done),
    .q    (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      pend_r           <= 1'b0;
      out_valid_r      <= 1'b0;
      start_angle_r    <= '0;
      end_angle_r      <= '0;
      move_speed_r     <= '0;
      stiffness_gain_r <= '0;
      damping_gain_r   <= '0;
      motor_number_r   <= '0;
      bus_number_r     <= '0;
      in_motion_r      <= 1'b0;
      elapsed_r        <= '0;
      duration_r       <= '0;
      start_rotor_r    <= '0;
      end_rotor_r      <= '0;
      dist_r           <= '0;
      hold_r           <= '0;
      kp_r             <= '0;
      kd_r             <= '0;
    end else begin
      // The result register loads in the emit step once it is free or being
      // taken, and empties when the sink takes it.
      if ((state_r == ST_EMIT) && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_valid) begin
        case (cfg_index)
          qtg_pkg::REG_START_ANGLE:    start_angle_r    <= cfg_data;
          qtg_pkg::REG_END_ANGLE:      end_angle_r      <= cfg_data;
          qtg_pkg::REG_MOVE_SPEED:     move_speed_r     <= cfg_data;
          qtg_pkg::REG_STIFFNESS_GAIN: stiffness_gain_r <= cfg_data;
          qtg_pkg::REG_DAMPING_GAIN:   damping_gain_r   <= cfg_data;
          qtg_pkg::REG_MOTOR_NUMBER:   motor_number_r   <= cfg_data[3:0];
          qtg_pkg::REG_BUS_NUMBER:     bus_number_r     <= cfg_data[1:0];
          default: begin
            // Indexes beyond the register list are dropped.
          end
        endcase
      end

      // Each arithmetic step first launches its unit, then waits for the
      // done pulse and captures the result.
      if ((is_mul || is_div) && !pend_r) begin
        pend_r <= 1'b1;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            if (in_word.command == qtg_pkg::CMD_START) begin
              // A start with zero speed is ignored altogether.
              if (move_speed_r != 32'd0) begin
                state_r <= ST_KP;
              end
            end else if (in_motion_r) begin
              elapsed_r <= elapsed_sum[32] ? 32'hFFFF_FFFF : elapsed_sum[31:0];
              state_r   <= ST_CHK;
            end else begin
              pos_r   <= hold_r;
              vel_r   <= '0;
              state_r <= ST_EMIT;
            end
          end
        end
        ST_KP: begin
          if (pend_r && div_done) begin
            pend_r  <= 1'b0;
            kp_r    <= div_q[31:0];
            state_r <= ST_KD;
          end
        end
        ST_KD: begin
          if (pend_r && div_done) begin
            pend_r  <= 1'b0;
            kd_r    <= div_q[31:0];
            state_r <= ST_SR;
          end
        end
        ST_SR: begin
          if (pend_r && mul_done) begin
            pend_r        <= 1'b0;
            start_rotor_r <= sat_mag(start_angle_r[31], 64'(mul_p[63:24]));
            state_r       <= ST_ER;
          end
        end
        ST_ER: begin
          if (pend_r && mul_done) begin
            pend_r      <= 1'b0;
            end_rotor_r <= sat_mag(end_angle_r[31], 64'(mul_p[63:24]));
            state_r     <= ST_DM;
          end
        end
        ST_DM: begin
          if (pend_r && mul_done) begin
            pend_r  <= 1'b0;
            tmp_r   <= mul_p;
            state_r <= ST_DD;
          end
        end
        ST_DD: begin
          if (pend_r && div_done) begin
            pend_r      <= 1'b0;
            duration_r  <= (div_q[63:32] != 32'd0) ? 32'hFFFF_FFFF : div_q[31:0];
            dist_r      <= {end_rotor_r[31], end_rotor_r} - {start_rotor_r[31], start_rotor_r};
            elapsed_r   <= '0;
            hold_r      <= start_rotor_r;
            in_motion_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        ST_CHK: begin
          if (elapsed_r >= duration_r) begin
            pos_r       <= end_rotor_r;
            hold_r      <= end_rotor_r;
            vel_r       <= '0;
            in_motion_r <= 1'b0;
            state_r     <= ST_EMIT;
          end else begin
            state_r <= ST_T;
          end
        end
        ST_T: begin
          if (pend_r && div_done) begin
            pend_r  <= 1'b0;
            t_r     <= div_q[29:0];
            state_r <= ST_P2;
          end
        end
        ST_P2: begin
          if (pend_r && mul_done) begin
            pend_r  <= 1'b0;
            t2_r    <= mul_p[59:30];
            state_r <= ST_P3;
          end
        end
        ST_P3: begin
          if (pend_r && mul_done) begin
            pend_r  <= 1'b0;
            t3_r    <= mul_p[59:30];
            state_r <= ST_P4;
          end
        end
        ST_P4: begin
          if (pend_r && mul_done) begin
            pend_r  <= 1'b0;
            t4_r    <= mul_p[59:30];
            state_r <= ST_P5;
          end
        end
        ST_P5: begin
          if (pend_r && mul_done) begin
            pend_r  <= 1'b0;
            t5_r    <= mul_p[59:30];
            state_r <= ST_POLY;
          end
        end
        ST_POLY: begin
          // Clamp the position shape to [0, 1] and the speed shape to
          // [0, 1.875], both in Q30.
          if (ps_raw < 36'sd0) begin
            ps_r <= '0;
          end else if (ps_raw > ONE_Q30) begin
            ps_r <= ONE_Q30[30:0];
          end else begin
            ps_r <= ps_raw[30:0];
          end
          if (vs_raw < 36'sd0) begin
            vs_r <= '0;
          end else if (vs_raw > VMAX_Q30) begin
            vs_r <= VMAX_Q30[30:0];
          end else begin
            vs_r <= vs_raw[30:0];
          end
          state_r <= ST_DP;
        end
        ST_DP: begin
          if (pend_r && mul_done) begin
            pend_r <= 1'b0;
            if (pos_sum > 36'sh0_7FFF_FFFF) begin
              pos_r <= 32'sh7FFF_FFFF;
            end else if (pos_sum < -36'sh0_8000_0000) begin
              pos_r <= 32'sh8000_0000;
            end else begin
              pos_r <= pos_sum[31:0];
            end
            state_r <= ST_DV1;
          end
        end
        ST_DV1: begin
          if (pend_r && mul_done) begin
            pend_r  <= 1'b0;
            tmp_r   <= {30'd0, mul_p[63:30]};
            state_r <= ST_DV2;
          end
        end
        ST_DV2: begin
          if (pend_r && mul_done) begin
            pend_r  <= 1'b0;
            tmp_r   <= mul_p;
            state_r <= ST_DV3;
          end
        end
        ST_DV3: begin
          if (pend_r && div_done) begin
            pend_r  <= 1'b0;
            vel_r   <= sat_mag(dist_r[32], div_q);
            hold_r  <= pos_r;
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!out_valid_r || !out_stall) begin
            out_word_r.position_cmd    <= pos_r;
            out_word_r.velocity_cmd    <= vel_r;
            out_word_r.torque_cmd      <= 1'b0;
            out_word_r.stiffness_out   <= kp_r;
            out_word_r.damping_out     <= kd_r;
            out_word_r.motor_out       <= motor_number_r;
            out_word_r.bus_out         <= bus_number_r;
            out_word_r.moving_flag     <= in_motion_r;
            state_r                    <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // A word is taken only in the idle state; the output register lets a new
  // word enter while the last result still waits.
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ----- rtl/qtg_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtg_checker
// Port-level checks of the trajectory generator, bound to the top level.
// ----------------------------------------------------------------------------
module qtg_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input qtg_pkg::in_word_t  in_word,
  input logic               out_valid,
  input logic               out_stall,
  input qtg_pkg::out_word_t out_word
);

  // A result stalled by the sink is held unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled result word changed");

  // A tick word always starts work, so the input closes behind it.
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_word.command == qtg_pkg::CMD_TICK) |=> in_stall)
    else $error("input open right after a tick");

  // Once the move is over the feedforward velocity is zero.
  a_stop_vel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.moving_flag |-> out_word.velocity_cmd == 32'sd0)
    else $error("nonzero velocity while not moving");

  // No result comes out of reset.
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind quintic_trajectory_generator_core qtg_checker u_qtg_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_word  (in_word),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_word (out_word)
);
